// File: sv/cstg_pkg.sv
`timescale 1ns / 1ps
package cstg_pkg;

  localparam int MOVE_WORDS   = 12;
  localparam int CRUISE_SCALE = 1024;
  localparam int CRUISE_SHIFT = $clog2(CRUISE_SCALE);

  // request commands
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STEP  = 2'd2;

  // config register indexes
  localparam logic [1:0] REG_MIN_STEP = 2'd0;
  localparam logic [1:0] REG_MIN_CALC = 2'd1;
  localparam logic [1:0] REG_HALT     = 2'd2;

  // move word indexes
  localparam int W_TOTAL   = 0;
  localparam int W_ACCSTOP = 1;
  localparam int W_DECSTRT = 2;
  localparam int W_REVSTRT = 3;
  localparam int W_A       = 4;
  localparam int W_M       = 5;
  localparam int W_F       = 6;
  localparam int W_S       = 7;
  localparam int W_C       = 8;
  localparam int W_T       = 9;
  localparam int W_D       = 10;
  localparam int W_NEED    = 11;

  localparam logic [31:0] LATE_BIAS = 32'd10000000;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL_AN, ST_MUL_SS, ST_SQRT, ST_CALC, ST_DIV, ST_NEED, ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    PH_ACCEL, PH_CRUISE, PH_DECEL, PH_REV
  } phase_t;

endpackage

// File: sv/cartesian_step_time_generator.sv
`timescale 1ns / 1ps
// Load and start requests are taken in the idle state; a step in the reuse window
// goes on through the need check and emit states. A recalculated step runs one or
// two serial multiplies and may also run the serial square root and the reuse-count divider.
// One request is worked at a time; the result waits in an output register.
// Reset (rst_n, synchronous, active low) clears counters, flags and config to
// defaults; move words hold no reset value and must be loaded before a start.
module cartesian_step_time_generator import cstg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [3:0]  in_param_index,
  input  logic [63:0] in_param_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_step_time,
  output logic        out_no_step,
  output logic        out_reverse_now,
  output logic        out_step_error,
  output logic        out_moving,
  output logic        out_last_step,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;

  logic [63:0] words_r [MOVE_WORDS];
  logic [15:0] msi_r, mci_r;
  logic        halt_r;

  logic [31:0] step_count_r, last_time_r, reuse_r, n_r, t_r, prev_r;
  logic [15:0] recalc_r;
  logic        active_r, error_r;
  logic [63:0] an_r;
  logic        res_nostep_r, res_rev_r;

  logic        out_valid_r, out_nostep_r, out_rev_r, out_err_r, out_mv_r, out_last_r;
  logic [31:0] out_time_r;

  logic [31:0] total, need, n_nxt, du;
  logic        acc_in, step_dead, reuse_go, too_fast, calc_hit, d_gt, emit_go, mv;

  logic        mul_start, mul_done, sqrt_start, sqrt_done, div_start, div_done;
  logic [63:0] mul_a, mul_p, radicand;
  logic [31:0] mul_b, root;
  logic [15:0] div_d, quot;

  assign total     = words_r[W_TOTAL][31:0];
  assign need      = words_r[W_NEED][31:0];
  assign n_nxt     = step_count_r + 32'd1;
  assign acc_in    = in_valid && in_ready;
  assign step_dead = !active_r || (step_count_r >= total);
  assign reuse_go  = (recalc_r > 16'd1) && (n_nxt != total);
  assign du        = t_r - prev_r;
  assign too_fast  = du[31] || (du < {16'b0, msi_r});
  assign calc_hit  = du < {16'b0, mci_r};
  assign d_gt      = words_r[W_D] > mul_p;
  assign emit_go   = !out_valid_r || out_ready;
  assign mv        = active_r && (step_count_r < total);

  always_comb begin
    if (n_nxt < words_r[W_ACCSTOP][31:0])      phase_nxt = PH_ACCEL;
    else if (n_nxt < words_r[W_DECSTRT][31:0]) phase_nxt = PH_CRUISE;
    else if (n_nxt < words_r[W_REVSTRT][31:0]) phase_nxt = PH_DECEL;
    else                                       phase_nxt = PH_REV;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (acc_in && in_command == CMD_STEP) begin
          if (step_dead)     state_nxt = ST_EMIT;
          else if (reuse_go) state_nxt = ST_NEED;
          else               state_nxt = ST_MUL_AN;
        end
      end
      ST_MUL_AN: begin
        if (mul_done) begin
          unique case (phase_r)
            PH_ACCEL:  state_nxt = ST_MUL_SS;
            PH_CRUISE: state_nxt = ST_CALC;
            PH_DECEL:  state_nxt = d_gt ? ST_SQRT : ST_CALC;
            default:   state_nxt = ST_SQRT;
          endcase
        end
      end
      ST_MUL_SS: if (mul_done) state_nxt = ST_SQRT;
      ST_SQRT:   if (sqrt_done) state_nxt = ST_CALC;
      ST_CALC: begin
        if (recalc_r == 16'd1) state_nxt = ST_NEED;
        else if (too_fast)     state_nxt = halt_r ? ST_EMIT : ST_NEED;
        else if (calc_hit)     state_nxt = ST_DIV;
        else                   state_nxt = ST_NEED;
      end
      ST_DIV:  if (div_done) state_nxt = ST_NEED;
      ST_NEED: state_nxt = ST_EMIT;
      ST_EMIT: if (emit_go) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // unit control
  always_comb begin
    in_ready   = (state_r == ST_IDLE);
    mul_start  = 1'b0;
    sqrt_start = 1'b0;
    div_start  = 1'b0;
    mul_a      = words_r[W_A];
    mul_b      = n_nxt;
    radicand   = mul_p - words_r[W_F];
    unique case (state_r)
      ST_IDLE: begin
        mul_start = acc_in && (in_command == CMD_STEP) && !step_dead && !reuse_go;
        if (phase_nxt == PH_CRUISE) mul_a = {32'b0, words_r[W_M][31:0]};
      end
      ST_MUL_AN: begin
        mul_start  = mul_done && (phase_r == PH_ACCEL);
        mul_a      = {32'b0, words_r[W_S][31:0]};
        mul_b      = words_r[W_S][31:0];
        sqrt_start = mul_done && ((phase_r == PH_REV) || (phase_r == PH_DECEL && d_gt));
        if (phase_r == PH_DECEL) radicand = words_r[W_D] - mul_p;
      end
      ST_MUL_SS: begin
        sqrt_start = mul_done;
        radicand   = mul_p + an_r;
      end
      ST_CALC: div_start = (recalc_r != 16'd1) && !too_fast && calc_hit;
      default: ;
    endcase
  end

  assign div_d = (du[15:0] == 16'd0) ? 16'd1 : du[15:0];

  cstg_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .mcand(mul_a), .mplier(mul_b),
    .done(mul_done), .product(mul_p)
  );

  cstg_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sqrt_start), .radicand(radicand),
    .done(sqrt_done), .root(root)
  );

  cstg_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(mci_r), .divisor(div_d),
    .done(div_done), .quotient(quot)
  );

  // move words: no reset
  always_ff @(posedge clk) begin
    if (acc_in && in_command == CMD_LOAD && in_param_index < 4'(MOVE_WORDS))
      words_r[in_param_index] <= in_param_value;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      msi_r  <= 16'd1;
      mci_r  <= 16'd256;
      halt_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_STEP: msi_r  <= cfg_data;
        REG_MIN_CALC: mci_r  <= cfg_data;
        REG_HALT:     halt_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      step_count_r <= '0;
      last_time_r  <= '0;
      recalc_r     <= '0;
      reuse_r      <= '0;
      active_r     <= 1'b0;
      error_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_ready && !(state_r == ST_EMIT && emit_go))
        out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (acc_in && in_command == CMD_START) begin
            step_count_r <= '0;
            last_time_r  <= '0;
            recalc_r     <= '0;
            reuse_r      <= '0;
            error_r      <= 1'b0;
            active_r     <= 1'b1;
          end else if (acc_in && in_command == CMD_STEP && !step_dead) begin
            step_count_r <= n_nxt;
            if (reuse_go) begin
              recalc_r    <= recalc_r - 16'd1;
              last_time_r <= last_time_r + reuse_r;
            end
          end
        end
        ST_CALC: begin
          last_time_r <= t_r;
          if (recalc_r == 16'd1) begin
            recalc_r <= '0;
          end else if (too_fast) begin
            error_r <= 1'b1;
            if (halt_r) reuse_r <= du;
          end else if (calc_hit) begin
            reuse_r <= du;
          end
        end
        ST_DIV: begin
          if (div_done) recalc_r <= (quot == 16'hFFFF) ? 16'hFFFF : quot + 16'd1;
        end
        ST_NEED: begin
          if (t_r > need) begin
            if (n_r == total) begin
              last_time_r <= need;
            end else begin
              error_r <= 1'b1;
              if (halt_r) reuse_r <= LATE_BIAS + t_r;
            end
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            out_valid_r <= 1'b1;
            if (!mv) active_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // step datapath and result payload
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        n_r          <= n_nxt;
        prev_r       <= last_time_r;
        phase_r      <= phase_nxt;
        res_nostep_r <= step_dead;
        res_rev_r    <= !step_dead && !reuse_go && phase_nxt == PH_REV
                        && n_nxt == words_r[W_REVSTRT][31:0];
        t_r          <= last_time_r + reuse_r;
      end
      ST_MUL_AN: begin
        if (mul_done) begin
          an_r <= mul_p;
          if (phase_r == PH_CRUISE)
            t_r <= mul_p[CRUISE_SHIFT +: 32] + words_r[W_C][31:0];
          else
            t_r <= words_r[W_T][31:0];
        end
      end
      ST_SQRT: begin
        if (sqrt_done) begin
          unique case (phase_r)
            PH_ACCEL: t_r <= root - words_r[W_S][31:0];
            PH_DECEL: t_r <= words_r[W_T][31:0] - root;
            default:  t_r <= words_r[W_T][31:0] + root;
          endcase
        end
      end
      ST_CALC: begin
        if (recalc_r != 16'd1 && too_fast && halt_r) res_nostep_r <= 1'b1;
      end
      ST_NEED: begin
        if (t_r > need) begin
          if (n_r == total) t_r <= need;
          else if (halt_r)  res_nostep_r <= 1'b1;
        end
      end
      ST_EMIT: begin
        if (emit_go) begin
          out_time_r   <= res_nostep_r ? 32'd0 : t_r;
          out_nostep_r <= res_nostep_r;
          out_rev_r    <= res_rev_r;
          out_err_r    <= error_r;
          out_mv_r     <= mv;
          out_last_r   <= !res_nostep_r && (n_r == total);
        end
      end
      default: ;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_step_time   = out_time_r;
  assign out_no_step     = out_nostep_r;
  assign out_reverse_now = out_rev_r;
  assign out_step_error  = out_err_r;
  assign out_moving      = out_mv_r;
  assign out_last_step   = out_last_r;

  a_nostep_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_step |-> out_step_time == 32'd0 && !out_last_step)
    else $error("no-step result carries a time or last flag");

  a_last_not_moving: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_step |-> !out_moving)
    else $error("last step reported while still moving");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command == CMD_START |=>
      step_count_r == 32'd0 && !error_r && active_r)
    else $error("start request did not clear move counters");

  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({mul_start, sqrt_start, div_start}) <= 1)
    else $error("two arithmetic units started together");
endmodule

// File: sv/cstg_mul.sv
`timescale 1ns / 1ps
// shift-add multiply, one multiplier bit per cycle, low 64 bits kept
module cstg_mul import cstg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] mcand,
  input  logic [31:0] mplier,
  output logic        done,
  output logic [63:0] product
);
  logic        busy_r, done_r;
  logic [4:0]  cnt_r;
  logic [63:0] acc_r, a_r;
  logic [31:0] b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      a_r   <= mcand;
      b_r   <= mplier;
    end else if (busy_r) begin
      if (b_r[0]) acc_r <= acc_r + a_r;
      a_r <= {a_r[62:0], 1'b0};
      b_r <= {1'b0, b_r[31:1]};
    end
  end

  assign done    = done_r;
  assign product = acc_r;
endmodule

// File: sv/cstg_sqrt.sv
`timescale 1ns / 1ps
// digit-by-digit square root, one root bit per cycle, rounds down
module cstg_sqrt import cstg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);
  logic        busy_r, done_r;
  logic [4:0]  cnt_r;
  logic [63:0] v_r;
  logic [34:0] rem_r;
  logic [31:0] root_r;
  logic [34:0] rem_sh, trial;
  logic        ge;

  assign rem_sh = {rem_r[32:0], v_r[63:62]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r    <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      v_r    <= {v_r[61:0], 2'b00};
      rem_r  <= ge ? rem_sh - trial : rem_sh;
      root_r <= {root_r[30:0], ge};
    end
  end

  assign done = done_r;
  assign root = root_r;
endmodule

// File: sv/cstg_div.sv
`timescale 1ns / 1ps
// restoring divide, one quotient bit per cycle
module cstg_div import cstg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [15:0] quotient
);
  logic        busy_r, done_r;
  logic [3:0]  cnt_r;
  logic [15:0] q_r, d_r;
  logic [16:0] rem_r, rem_sh;
  logic        ge;

  assign rem_sh = {rem_r[15:0], q_r[15]};
  assign ge     = rem_sh >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      d_r   <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? rem_sh - {1'b0, d_r} : rem_sh;
      q_r   <= {q_r[14:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = q_r;
endmodule

// File: tb/cartesian_step_time_checker.sv
`timescale 1ns / 1ps
module cartesian_step_time_checker import cstg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [3:0]  in_param_index,
  input  logic [63:0] in_param_value,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_step_time,
  input  logic        out_no_step,
  input  logic        out_reverse_now,
  input  logic        out_step_error,
  input  logic        out_moving,
  input  logic        out_last_step,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending_steps
);

  typedef struct packed {
    logic [31:0] step_time;
    logic        no_step;
    logic        reverse_now;
    logic        step_error;
    logic        moving;
    logic        last_step;
  } step_result_t;

  logic [63:0] words [MOVE_WORDS];
  logic [31:0] step_num, prev_time, reuse_iv;
  logic [15:0] reuse_left;
  logic        active, err_flag;
  logic [15:0] min_step, min_calc;
  logic        halt_err;
  step_result_t expected_steps[$];

  function automatic logic [31:0] isqrt64(logic [63:0] v);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res[31:0];
  endfunction

  function automatic logic [31:0] lo32(int i);
    return words[i][31:0];
  endfunction

  function automatic step_result_t make_result(logic [31:0] t, logic nostep, logic rev,
                                               logic last);
    step_result_t r;
    logic mv;
    mv = active && (step_num < lo32(W_TOTAL));
    if (!mv) active = 1'b0;
    r.step_time   = nostep ? 32'd0 : t;
    r.no_step     = nostep;
    r.reverse_now = rev;
    r.step_error  = err_flag;
    r.moving      = mv;
    r.last_step   = !nostep && last;
    return r;
  endfunction

  function automatic step_result_t predict_step();
    logic [31:0] total, n, t, prevt, du, dv, c, need;
    logic [63:0] an, s, d;
    logic        rev;
    longint      iv;
    rev = 1'b0;
    total = lo32(W_TOTAL);
    if (!active || step_num >= total) begin
      active = 1'b0;
      return make_result(0, 1'b1, 1'b0, 1'b0);
    end
    n = step_num + 1;
    step_num = n;
    if (reuse_left > 1 && n != total) begin
      reuse_left--;
      t = prev_time + reuse_iv;
      prev_time = t;
    end else begin
      prevt = prev_time;
      an = words[W_A] * {32'd0, n};
      if (n < lo32(W_ACCSTOP)) begin
        s = {32'd0, lo32(W_S)};
        t = isqrt64(s * s + an) - s[31:0];
      end else if (n < lo32(W_DECSTRT)) begin
        t = 32'((64'(lo32(W_M)) * 64'(n)) / CRUISE_SCALE) + lo32(W_C);
      end else if (n < lo32(W_REVSTRT)) begin
        d = words[W_D];
        t = (d > an) ? lo32(W_T) - isqrt64(d - an) : lo32(W_T);
      end else begin
        rev = (n == lo32(W_REVSTRT));
        t = lo32(W_T) + isqrt64(an - words[W_F]);
      end
      prev_time = t;
      if (reuse_left == 1) begin
        reuse_left = 0;
      end else begin
        du = t - prevt;
        iv = longint'($signed(du));
        if (iv < longint'(min_step)) begin
          err_flag = 1'b1;
          if (halt_err) begin
            reuse_iv = du;
            return make_result(0, 1'b1, rev, 1'b0);
          end
        end else if (iv < longint'(min_calc)) begin
          dv = (du != 0) ? du : 32'd1;
          c = 32'(min_calc) / dv + 1;
          reuse_iv = du;
          reuse_left = (c > 32'hFFFF) ? 16'hFFFF : c[15:0];
        end
      end
    end
    need = lo32(W_NEED);
    if (t > need) begin
      if (n == total) begin
        t = need;
        prev_time = t;
      end else begin
        err_flag = 1'b1;
        if (halt_err) begin
          reuse_iv = LATE_BIAS + t;
          return make_result(0, 1'b1, rev, 1'b0);
        end
      end
    end
    return make_result(t, 1'b0, rev, n == total);
  endfunction

  assign pending_steps = expected_steps.size();

  always @(posedge clk) begin
    step_result_t e, a;
    if (!rst_n) begin
      foreach (words[i]) words[i] <= 64'd0;
      step_num <= 0; prev_time <= 0; reuse_left <= 0; reuse_iv <= 0;
      active <= 0; err_flag <= 0;
      min_step <= 16'd1; min_calc <= 16'd256; halt_err <= 0;
      fail_count <= 0;
      expected_steps.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MIN_STEP: min_step = cfg_data;
          REG_MIN_CALC: min_calc = cfg_data;
          REG_HALT:     halt_err = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        a = '{out_step_time, out_no_step, out_reverse_now, out_step_error, out_moving,
              out_last_step};
        if (expected_steps.size() == 0) begin
          $error("step result with nothing expected");
          fail_count++;
        end else begin
          e = expected_steps.pop_front();
          if (a.step_time !== e.step_time) begin
            $error("step_time exp %0d got %0d", e.step_time, a.step_time); fail_count++;
          end
          if (a.no_step !== e.no_step) begin
            $error("no_step exp %0d got %0d", e.no_step, a.no_step); fail_count++;
          end
          if (a.reverse_now !== e.reverse_now) begin
            $error("reverse_now exp %0d got %0d", e.reverse_now, a.reverse_now);
            fail_count++;
          end
          if (a.step_error !== e.step_error) begin
            $error("step_error exp %0d got %0d", e.step_error, a.step_error); fail_count++;
          end
          if (a.moving !== e.moving) begin
            $error("moving exp %0d got %0d", e.moving, a.moving); fail_count++;
          end
          if (a.last_step !== e.last_step) begin
            $error("last_step exp %0d got %0d", e.last_step, a.last_step); fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        case (in_command)
          CMD_LOAD: if (in_param_index < MOVE_WORDS) words[in_param_index] = in_param_value;
          CMD_START: begin
            step_num = 0; prev_time = 0; reuse_left = 0; reuse_iv = 0;
            err_flag = 0; active = 1;
          end
          CMD_STEP: expected_steps.push_back(predict_step());
          default: ;
        endcase
      end
    end
  end

endmodule

// File: tb/cartesian_step_time_generator_test.sv
`timescale 1ns / 1ps
module cartesian_step_time_generator_test;
  import cstg_pkg::*;

  logic        clk = 0, rst_n = 0;
  logic        in_valid = 0, in_ready;
  logic [1:0]  in_command = CMD_LOAD;
  logic [3:0]  in_param_index = 0;
  logic [63:0] in_param_value = 0;
  logic        out_valid, out_ready = 0;
  logic [31:0] out_step_time;
  logic        out_no_step, out_reverse_now, out_step_error, out_moving, out_last_step;
  logic        cfg_we = 0;
  logic [1:0]  cfg_index = REG_MIN_STEP;
  logic [15:0] cfg_data = 0;
  int          fail_count, pending_steps;
  int          sent;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  cartesian_step_time_generator u_top (.*);
  cartesian_step_time_checker u_chk (.*);

  // valid stays high into the next request when no idle cycles are drawn
  task automatic send_request(logic [1:0] cmd, logic [3:0] idx, logic [63:0] val);
    int gap;
    gap = $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1; in_command <= cmd; in_param_index <= idx; in_param_value <= val;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    sent++;
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending_steps != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic load_move(int total);
    logic [31:0] acc, dec, rv;
    acc = $urandom_range(0, total);
    dec = $urandom_range(acc, total);
    rv  = $urandom_range(dec, total + 1);
    send_request(CMD_LOAD, 4'(W_TOTAL), {$urandom, 32'(total)});
    send_request(CMD_LOAD, 4'(W_ACCSTOP), {$urandom, acc});
    send_request(CMD_LOAD, 4'(W_DECSTRT), {$urandom, dec});
    send_request(CMD_LOAD, 4'(W_REVSTRT), {$urandom, rv});
    send_request(CMD_LOAD, 4'(W_A), ($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
                                : 64'($urandom_range(1, 1 << 20)));
    send_request(CMD_LOAD, 4'(W_M), {$urandom, 32'($urandom_range(0, 1 << 20))});
    send_request(CMD_LOAD, 4'(W_F), {$urandom, $urandom});
    send_request(CMD_LOAD, 4'(W_S), {$urandom, 32'($urandom_range(0, 5000))});
    send_request(CMD_LOAD, 4'(W_C), {$urandom, $urandom});
    send_request(CMD_LOAD, 4'(W_T), {$urandom, $urandom});
    send_request(CMD_LOAD, 4'(W_D), {$urandom, $urandom});
    send_request(CMD_LOAD, 4'(W_NEED), ($urandom_range(0, 3) == 0) ? {$urandom, $urandom}
                                   : {$urandom, 32'hFFFF_FFFF});
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1;
    // directed: extreme words, bad command and index, step with no move
    send_request(CMD_STEP, 0, 0);
    send_request(2'd3, 0, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(CMD_LOAD, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(CMD_LOAD, 4'd12, 0);
    for (int i = 0; i < MOVE_WORDS; i++)
      send_request(CMD_LOAD, 4'(i), 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(CMD_START, 0, 0);
    send_request(CMD_STEP, 0, 0);
    send_request(CMD_STEP, 0, 0);
    drain();
    write_cfg(REG_MIN_STEP, 16'hFFFF);
    write_cfg(REG_MIN_CALC, 16'hFFFF);
    write_cfg(REG_HALT, 16'hFFFF);
    for (int i = 0; i < MOVE_WORDS; i++) send_request(CMD_LOAD, 4'(i), 0);
    send_request(CMD_LOAD, 4'(W_TOTAL), 3);
    send_request(CMD_START, 0, 0);
    repeat (4) send_request(CMD_STEP, 0, 0);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      write_cfg(REG_MIN_STEP, (ph == 0) ? 16'd0 : 16'($urandom_range(0, 300)));
      write_cfg(REG_MIN_CALC, (ph == 1) ? 16'd1 : (ph == 2) ? 16'hFFFF
                              : 16'($urandom_range(1, 2000)));
      write_cfg(REG_HALT, 16'(ph % 2));
      while (sent < (ph + 1) * 140) begin
        int total;
        total = $urandom_range(1, 40);
        load_move(total);
        send_request(CMD_START, 0, 0);
        repeat (total + $urandom_range(0, 2)) begin
          if ($urandom_range(0, 19) == 0)
            send_request(2'($urandom_range(0, 3)), 4'($urandom), {$urandom, $urandom});
          else
            send_request(CMD_STEP, 0, 0);
        end
      end
      drain();
    end
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  initial begin
    @(posedge rst_n);
    forever begin
      int gap;
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        out_ready <= 0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    #20ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// File: files.f
sv/cstg_pkg.sv
sv/cstg_mul.sv
sv/cstg_sqrt.sv
sv/cstg_div.sv
sv/cartesian_step_time_generator.sv
tb/cartesian_step_time_checker.sv
tb/cartesian_step_time_generator_test.sv
